/* rtl/line_prefix_rewriter_macros.svh */
// Assertion macros shared by the line prefix rewriter modules.
`ifndef LINE_PREFIX_REWRITER_MACROS_SVH
`define LINE_PREFIX_REWRITER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line_prefix_rewriter: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line_prefix_rewriter: assertion failed");
`else
`define LPR_ASSERT_SAME(label, ante, cons)
`define LPR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/lpr_pkg.sv */
// Types, constants and helpers shared by the line prefix rewriter modules.
`timescale 1ns / 1ps
package lpr_pkg;

    localparam int          CFG_INDEX_W = 3;
    localparam int          LEN_FIELD_W = 24;
    localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
    localparam logic [LEN_FIELD_W-1:0] LEN_FIELD_SAT = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STRIP_LOW    = 3'd0,
        CFG_STRIP_HIGH   = 3'd1,
        CFG_STRIP_LENGTH = 3'd2,
        CFG_ADD_LOW      = 3'd3,
        CFG_ADD_HIGH     = 3'd4,
        CFG_ADD_LENGTH   = 3'd5
    } t_cfg_index;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic                   out_kind;
        logic [7:0]             out_byte;
        logic                   run_last;
        logic [LEN_FIELD_W-1:0] payload_length;
        logic                   any_rewritten;
    } t_out;

    typedef struct packed {
        logic [63:0] strip_low;
        logic [63:0] strip_high;
        logic [4:0]  strip_length;
        logic [63:0] add_low;
        logic [63:0] add_high;
        logic [4:0]  add_length;
    } t_cfg;

    // One item's worth of output work: held bytes, then the item byte or the
    // replacement prefix, then an optional summary.
    typedef struct packed {
        logic [4:0]             flush_cnt;
        logic                   body;
        logic [7:0]             body_byte;
        logic [4:0]             add_cnt;
        logic                   sum;
        logic [LEN_FIELD_W-1:0] sum_len;
        logic                   sum_any;
    } t_job;

    function automatic logic [7:0] prefix_byte(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [3:0] idx);
        logic [63:0] w;
        w = idx[3] ? hi : lo;
        return w[idx[2:0]*8 +: 8];
    endfunction

endpackage

/* rtl/line_prefix_rewriter.sv */
// Top level of the line prefix rewriter: configuration, line tracking and result sequencing.
`timescale 1ns / 1ps
// A byte's first result passes from the job registers to the output register. Throughput:
// one byte per cycle while each byte yields a single result and the output is not stalled;
// a byte with more results (held strip bytes, the replacement prefix, a summary) holds the
// sequencer until done. A byte that is held back yields no result and never stalls the input.
// Reset is synchronous and active low; it clears the line state and all configuration to zero.
module line_prefix_rewriter #(
    parameter int MAX_PREFIX  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lpr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lpr_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lpr_pkg::t_out                   o_out
);
    import lpr_pkg::*;

    // Configuration writes are taken in every cycle; they are only expected
    // while the block is idle, so no interlock with the data path is needed.
    t_cfg cfg;
    t_job job;
    logic job_load;
    logic job_free;
    logic in_accept;

    assign o_cfg_ready = 1'b1;

    // The input is taken whenever the sequencer either holds no job or is
    // handing over the last result of its job in this very cycle, so a
    // stream of single-result bytes runs without a bubble.
    assign o_in_ready = job_free;
    assign in_accept  = i_in_valid && o_in_ready;

    lpr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The scanner updates the match position, line phase, running length and
    // rewrite flag on every accepted byte, and describes the results the byte
    // causes as a compact job.
    lpr_scan #(
        .MAX_PREFIX  (MAX_PREFIX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_accept   (in_accept),
        .i_item     (i_in),
        .o_job_load (job_load),
        .o_job      (job)
    );

    // The sequencer expands a job into result transfers: held strip bytes are
    // regenerated from the configuration, then either the byte itself or the
    // replacement prefix, then the summary at the end of a payload.
    lpr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_load  (job_load),
        .i_job       (job),
        .o_job_free  (job_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

/* rtl/lpr_cfg.sv */
// Configuration register file of the line prefix rewriter.
`timescale 1ns / 1ps
module lpr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [lpr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output lpr_pkg::t_cfg                  o_cfg
);
    import lpr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_STRIP_LOW:    r_cfg.strip_low    <= i_cfg_data;
                CFG_STRIP_HIGH:   r_cfg.strip_high   <= i_cfg_data;
                CFG_STRIP_LENGTH: r_cfg.strip_length <= i_cfg_data[4:0];
                CFG_ADD_LOW:      r_cfg.add_low      <= i_cfg_data;
                CFG_ADD_HIGH:     r_cfg.add_high     <= i_cfg_data;
                CFG_ADD_LENGTH:   r_cfg.add_length   <= i_cfg_data[4:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/lpr_scan.sv */
// Line state tracker: matches the strip prefix and turns each byte into a job.
`timescale 1ns / 1ps
`include "line_prefix_rewriter_macros.svh"
module lpr_scan #(
    parameter int MAX_PREFIX  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpr_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  lpr_pkg::t_in  i_item,
    output logic          o_job_load,
    output lpr_pkg::t_job o_job
);
    import lpr_pkg::*;

    localparam int PW = $clog2(MAX_PREFIX + 1);
    localparam int SW = LENGTH_BITS + 1;
    localparam int CW = (LENGTH_BITS > LEN_FIELD_W) ? LENGTH_BITS : LEN_FIELD_W;
    localparam logic [LENGTH_BITS-1:0] LEN_SAT = '1;

    logic [PW-1:0]          r_mp, n_mp;
    logic                   r_copy, n_copy;
    logic [LENGTH_BITS-1:0] r_count, n_count;
    logic                   r_matched, n_matched;

    logic [PW-1:0]          slen, alen;
    logic [PW-1:0]          flush, add;
    logic                   body;
    logic [7:0]             sbyte;
    logic [4:0]             n_bytes;
    logic [SW-1:0]          count_sum;
    logic [LENGTH_BITS-1:0] count_sat;
    logic [CW-1:0]          count_wide;

    assign slen = (i_cfg.strip_length > 5'(MAX_PREFIX)) ? PW'(MAX_PREFIX)
                                                        : PW'(i_cfg.strip_length);
    assign alen = (i_cfg.add_length > 5'(MAX_PREFIX)) ? PW'(MAX_PREFIX)
                                                      : PW'(i_cfg.add_length);
    assign sbyte = prefix_byte(i_cfg.strip_low, i_cfg.strip_high, 4'(r_mp));

    always_comb begin
        flush     = '0;
        add       = '0;
        body      = 1'b0;
        n_mp      = r_mp;
        n_copy    = r_copy;
        n_matched = r_matched;
        priority if (slen == '0) begin
            flush  = r_mp;
            body   = 1'b1;
            n_mp   = '0;
            n_copy = 1'b0;
        end else if (!r_copy) begin
            priority if (i_item.in_byte == NEWLINE_BYTE) begin
                flush = r_mp;
                body  = 1'b1;
                n_mp  = '0;
            end else if (r_mp < slen && i_item.in_byte == sbyte) begin
                if (r_mp + PW'(1) == slen) begin
                    add       = alen;
                    n_mp      = '0;
                    n_matched = 1'b1;
                    n_copy    = 1'b1;
                end else begin
                    n_mp = r_mp + PW'(1);
                end
            end else begin
                flush  = r_mp;
                body   = 1'b1;
                n_mp   = '0;
                n_copy = 1'b1;
            end
        end else begin
            body = 1'b1;
            if (i_item.in_byte == NEWLINE_BYTE) begin
                n_copy = 1'b0;
            end
        end
        // A partial match still held at the end of the payload is flushed. It
        // only arises when nothing else was emitted for this byte.
        if (i_item.in_last) begin
            flush = flush + n_mp;
        end
    end

    assign n_bytes    = 5'(flush) + 5'(body) + 5'(add);
    assign count_sum  = {1'b0, r_count} + SW'(n_bytes);
    assign count_sat  = (count_sum > SW'(LEN_SAT)) ? LEN_SAT : count_sum[LENGTH_BITS-1:0];
    assign count_wide = CW'(count_sat);
    assign n_count    = count_sat;

    always_comb begin
        o_job.flush_cnt = 5'(flush);
        o_job.body      = body;
        o_job.body_byte = i_item.in_byte;
        o_job.add_cnt   = 5'(add);
        o_job.sum       = i_item.in_last;
        o_job.sum_len   = (count_wide > CW'(LEN_FIELD_SAT)) ? LEN_FIELD_SAT
                                                           : count_wide[LEN_FIELD_W-1:0];
        o_job.sum_any   = n_matched;
    end

    assign o_job_load = i_accept && (flush != '0 || body || add != '0 || i_item.in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp      <= '0;
            r_copy    <= 1'b0;
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (i_accept) begin
            if (i_item.in_last) begin
                r_mp      <= '0;
                r_copy    <= 1'b0;
                r_count   <= '0;
                r_matched <= 1'b0;
            end else begin
                r_mp      <= n_mp;
                r_copy    <= n_copy;
                r_count   <= n_count;
                r_matched <= n_matched;
            end
        end
    end

    `LPR_ASSERT_SAME(a_held_below_max, 1'b1, r_mp < PW'(MAX_PREFIX))
    `LPR_ASSERT_NEXT(a_last_clears, i_accept && i_item.in_last,
                     r_mp == '0 && !r_copy && r_count == '0 && !r_matched)
    `LPR_ASSERT_SAME(a_add_alone, i_accept && add != '0, !body && flush == '0)

endmodule

/* rtl/lpr_emit.sv */
// Result sequencer: plays out one job a result at a time into the output register.
`timescale 1ns / 1ps
`include "line_prefix_rewriter_macros.svh"
module lpr_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpr_pkg::t_cfg i_cfg,
    input  logic          i_job_load,
    input  lpr_pkg::t_job i_job,
    output logic          o_job_free,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lpr_pkg::t_out o_out
);
    import lpr_pkg::*;

    logic                   r_job_valid;
    logic [3:0]             r_fidx;
    logic [4:0]             r_fleft;
    logic                   r_body;
    logic [7:0]             r_byte;
    logic [3:0]             r_aidx;
    logic [4:0]             r_aleft;
    logic                   r_sum;
    logic [LEN_FIELD_W-1:0] r_len;
    logic                   r_any;

    logic r_out_valid;
    t_out r_out;

    t_out cur;
    logic cur_last;
    logic out_load;

    always_comb begin
        cur          = '0;
        cur.out_kind = KIND_BYTE;
        cur_last     = 1'b0;
        priority if (r_fleft != '0) begin
            cur.out_byte = prefix_byte(i_cfg.strip_low, i_cfg.strip_high, r_fidx);
            cur_last     = r_fleft == 5'd1 && !r_body && r_aleft == '0 && !r_sum;
        end else if (r_body) begin
            cur.out_byte = r_byte;
            cur_last     = r_aleft == '0 && !r_sum;
        end else if (r_aleft != '0) begin
            cur.out_byte = prefix_byte(i_cfg.add_low, i_cfg.add_high, r_aidx);
            cur_last     = r_aleft == 5'd1 && !r_sum;
        end else begin
            cur.out_kind       = KIND_SUMMARY;
            cur.payload_length = r_len;
            cur.any_rewritten  = r_any;
            cur_last           = 1'b1;
        end
        cur.run_last = cur_last;
    end

    assign out_load   = r_job_valid && (!r_out_valid || i_out_ready);
    assign o_job_free = !r_job_valid || (out_load && cur_last);

    // A new job only arrives when the sequencer is empty or hands over the last
    // result of its job, so loading it replaces all of the job state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_fidx      <= '0;
            r_fleft     <= '0;
            r_body      <= 1'b0;
            r_aidx      <= '0;
            r_aleft     <= '0;
            r_sum       <= 1'b0;
        end else if (i_job_load) begin
            r_job_valid <= 1'b1;
            r_fidx      <= '0;
            r_fleft     <= i_job.flush_cnt;
            r_body      <= i_job.body;
            r_aidx      <= '0;
            r_aleft     <= i_job.add_cnt;
            r_sum       <= i_job.sum;
        end else if (out_load) begin
            priority if (r_fleft != '0) begin
                r_fleft <= r_fleft - 5'd1;
                r_fidx  <= r_fidx + 4'd1;
            end else if (r_body) begin
                r_body <= 1'b0;
            end else if (r_aleft != '0) begin
                r_aleft <= r_aleft - 5'd1;
                r_aidx  <= r_aidx + 4'd1;
            end else begin
                r_sum <= 1'b0;
            end
            if (cur_last) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_byte <= i_job.body_byte;
            r_len  <= i_job.sum_len;
            r_any  <= i_job.sum_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= cur;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `LPR_ASSERT_SAME(a_load_only_when_free, i_job_load, o_job_free)
    `LPR_ASSERT_SAME(a_summary_closes_run, r_out_valid && r_out.out_kind == KIND_SUMMARY,
                     r_out.run_last)
    `LPR_ASSERT_SAME(a_idle_job_empty, !r_job_valid,
                     r_fleft == '0 && !r_body && r_aleft == '0 && !r_sum)

endmodule

/* tb/sv/tb_line_prefix_rewriter.sv */
// Self-checking testbench for the line prefix rewriter: directed and random payloads.
`timescale 1ns / 1ps
module tb_line_prefix_rewriter;
    import lpr_pkg::*;

    // The highest index, which names no register. A write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    // Where the predictor stands within the current line.
    typedef enum logic [1:0] {
        LINE_MATCH = 2'd0,
        LINE_COPY  = 2'd1
    } t_line_state;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [63:0]            i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in                    i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out                   o_out;

    line_prefix_rewriter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // Bytes waiting to be offered, and the results that the block still owes us.
    t_in  byte_backlog[$];
    t_out rewritten_queue[$];
    int   bytes_queued = 0;
    int   bytes_taken = 0;
    int   fault_count = 0;

    // Handshake between the edge that accepts a byte and the edge that drives the next one.
    bit   byte_taken = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    bit   hold_started = 1'b0;
    // Set by the stimulus: ask for one long receiver hold, and switch all idling off.
    bit   pressure_armed = 1'b0;
    bit   quiet = 1'b0;

    // Our own copy of the configuration registers, updated as each write transfer completes.
    logic [63:0] strip_lo, strip_hi, add_lo, add_hi;
    logic [4:0]  strip_len, add_len;

    // Our own copy of the line state.
    logic [4:0]  held_count;
    t_line_state line_state;
    logic [23:0] emitted_len;
    logic        rewritten_seen;

    initial begin
        strip_lo = '0;
        strip_hi = '0;
        add_lo = '0;
        add_hi = '0;
        strip_len = '0;
        add_len = '0;
        held_count = '0;
        line_state = LINE_MATCH;
        emitted_len = '0;
        rewritten_seen = 1'b0;
    end

    // Lengths beyond the sixteen-byte prefix store count as the full store.
    function automatic int clamp_len(input logic [4:0] v);
        return (v > 5'd16) ? 16 : int'(v);
    endfunction

    function automatic logic [7:0] strip_at(input int idx);
        logic [127:0] both;
        both = {strip_hi, strip_lo};
        return both[(idx % 16) * 8 +: 8];
    endfunction

    function automatic logic [7:0] add_at(input int idx);
        logic [127:0] both;
        both = {add_hi, add_lo};
        return both[(idx % 16) * 8 +: 8];
    endfunction

    // Every emitted payload byte counts toward the new length, which sticks at all ones.
    task automatic push_byte(input logic [7:0] b);
        t_out r;
        r = '0;
        r.out_kind = KIND_BYTE;
        r.out_byte = b;
        rewritten_queue.push_back(r);
        if (emitted_len != '1) begin
            emitted_len = emitted_len + 1'b1;
        end
    endtask

    // Held bytes are known to equal the strip prefix, so they come back from the registers
    // as they stand now, which may differ from when the bytes arrived.
    task automatic release_held();
        int cnt;
        cnt = clamp_len(held_count);
        for (int i = 0; i < cnt; i++) begin
            push_byte(strip_at(i));
        end
        held_count = '0;
    endtask

    task automatic rewrite_byte(input t_in item);
        int          slen;
        int          alen;
        int          first;
        logic [7:0]  b;
        t_out        r;
        b = item.in_byte;
        slen = clamp_len(strip_len);
        alen = clamp_len(add_len);
        first = rewritten_queue.size();
        if (slen == 0) begin
            // No prefix configured: anything held from before is flushed and the byte passes.
            release_held();
            push_byte(b);
            line_state = LINE_MATCH;
        end else if (line_state == LINE_MATCH) begin
            if (b == NEWLINE_BYTE) begin
                // The line ended before the prefix was complete.
                release_held();
                push_byte(b);
            end else if (held_count < slen && b == strip_at(int'(held_count))) begin
                held_count = held_count + 1'b1;
                if (held_count == slen) begin
                    for (int i = 0; i < alen; i++) begin
                        push_byte(add_at(i));
                    end
                    held_count = '0;
                    rewritten_seen = 1'b1;
                    line_state = LINE_COPY;
                end
            end else begin
                // Mismatch, or the strip length shrank to the held count or below.
                release_held();
                push_byte(b);
                line_state = LINE_COPY;
            end
        end else begin
            push_byte(b);
            if (b == NEWLINE_BYTE) begin
                line_state = LINE_MATCH;
            end
        end
        if (item.in_last) begin
            release_held();
            r = '0;
            r.out_kind = KIND_SUMMARY;
            r.payload_length = emitted_len;
            r.any_rewritten = rewritten_seen;
            rewritten_queue.push_back(r);
            held_count = '0;
            line_state = LINE_MATCH;
            emitted_len = '0;
            rewritten_seen = 1'b0;
        end
        if (rewritten_queue.size() > first) begin
            rewritten_queue[rewritten_queue.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic report_field(input string name, input logic [23:0] want,
                                input logic [23:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Rising edge: take accepted bytes into the predictor and check accepted results.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                rewrite_byte(i_in);
                bytes_taken++;
                byte_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (rewritten_queue.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, o_out);
                    fault_count++;
                end else begin
                    want = rewritten_queue.pop_front();
                    report_field("out_kind", 24'(want.out_kind), 24'(o_out.out_kind));
                    report_field("out_byte", 24'(want.out_byte), 24'(o_out.out_byte));
                    report_field("run_last", 24'(want.run_last), 24'(o_out.run_last));
                    report_field("payload_length", want.payload_length, o_out.payload_length);
                    report_field("any_rewritten", 24'(want.any_rewritten),
                                 24'(o_out.any_rewritten));
                end
            end
        end
    end

    // Falling edge: the sender. Once a byte is offered it stays put until its transfer
    // completes; gaps fall only between bytes.
    always @(negedge i_clk) begin
        logic next_valid;
        t_in  next_item;
        next_valid = i_in_valid;
        next_item = i_in;
        if (byte_taken || !i_in_valid) begin
            byte_taken = 1'b0;
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (byte_backlog.size() > 0) begin
                if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 14) - 1;
                end else begin
                    next_valid = 1'b1;
                    next_item = byte_backlog.pop_front();
                end
            end
        end
        i_in_valid <= next_valid;
        i_in <= next_item;
    end

    // Falling edge: the receiver. Short random stalls, plus one long hold on request so
    // that the block backs up and has to refuse input.
    always @(negedge i_clk) begin
        logic next_ready;
        next_ready = 1'b1;
        if (pressure_armed && !hold_started) begin
            hold_started = 1'b1;
            hold_left = 150;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            next_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(1, 14) - 1;
            next_ready = 1'b0;
        end
        i_out_ready <= next_ready;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_STRIP_LOW:    strip_lo = data;
            CFG_STRIP_HIGH:   strip_hi = data;
            CFG_STRIP_LENGTH: strip_len = data[4:0];
            CFG_ADD_LOW:      add_lo = data;
            CFG_ADD_HIGH:     add_hi = data;
            CFG_ADD_LENGTH:   add_len = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_prefixes(input logic [4:0] slen, input logic [4:0] alen);
        write_reg(CFG_STRIP_LOW, {$urandom, $urandom});
        write_reg(CFG_STRIP_HIGH, {$urandom, $urandom});
        write_reg(CFG_STRIP_LENGTH, {$urandom, 27'd0, slen});
        write_reg(CFG_ADD_LOW, {$urandom, $urandom});
        write_reg(CFG_ADD_HIGH, {$urandom, $urandom});
        write_reg(CFG_ADD_LENGTH, {$urandom, 27'd0, alen});
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.in_byte = b;
        item.in_last = last;
        byte_backlog.push_back(item);
        bytes_queued++;
    endtask

    // Waits until every queued byte has been taken and every result has come back. A held
    // byte leaves nothing owed, so the task waits on before the registers are touched.
    task automatic drain_pipeline();
        do begin
            @(negedge i_clk);
        end while (bytes_taken != bytes_queued || rewritten_queue.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    // One payload built from lines shaped around the current strip prefix: full matches,
    // lines cut short, mismatches part way in, plain lines and now and then pure noise.
    task automatic queue_payload();
        t_in  pay[$];
        t_in  item;
        int   slen;
        int   lines;
        int   kind;
        int   cut;
        int   body;
        bit   done;
        slen = clamp_len(strip_len);
        lines = $urandom_range(1, 4);
        done = 1'b0;
        item.in_last = 1'b0;
        if ($urandom_range(0, 9) == 0) begin
            body = $urandom_range(1, 12);
            for (int i = 0; i < body; i++) begin
                item.in_byte = 8'($urandom_range(0, 255));
                pay.push_back(item);
            end
        end else begin
            for (int l = 0; l < lines && !done; l++) begin
                kind = $urandom_range(0, 9);
                if (slen == 0 && kind != 8) begin
                    kind = 7;
                end
                cut = (slen > 1) ? $urandom_range(1, slen - 1) : 0;
                if (kind <= 4) begin
                    for (int i = 0; i < slen; i++) begin
                        item.in_byte = strip_at(i);
                        pay.push_back(item);
                    end
                end else if (kind == 5 || kind == 6 || kind == 9) begin
                    for (int i = 0; i < cut; i++) begin
                        item.in_byte = strip_at(i);
                        pay.push_back(item);
                    end
                    if (kind == 6) begin
                        item.in_byte = strip_at(cut) ^ (8'h01 << $urandom_range(0, 7));
                        pay.push_back(item);
                    end
                end
                if (kind == 9) begin
                    // The payload ends while prefix bytes are still held.
                    done = 1'b1;
                end else begin
                    if (kind != 5 && kind != 8) begin
                        body = $urandom_range(0, 5);
                        for (int i = 0; i < body; i++) begin
                            item.in_byte = 8'($urandom_range(0, 255));
                            pay.push_back(item);
                        end
                    end
                    if (l < lines - 1 || $urandom_range(0, 1) == 0) begin
                        item.in_byte = NEWLINE_BYTE;
                        pay.push_back(item);
                    end
                end
            end
        end
        if (pay.size() == 0) begin
            item.in_byte = 8'($urandom_range(0, 255));
            pay.push_back(item);
        end
        pay[pay.size() - 1].in_last = 1'b1;
        foreach (pay[i]) begin
            queue_byte(pay[i].in_byte, pay[i].in_last);
        end
    endtask

    task automatic queue_phase(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            queue_payload();
        end
    endtask

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out of reset the strip length is zero, so bytes pass straight through.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'hA5, 1'b1);
        drain_pipeline();

        // Strip "/a/" and put "/xyz/" in its place.
        write_reg(CFG_STRIP_LOW, 64'h0000_0000_002F_612F);
        write_reg(CFG_STRIP_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_STRIP_LENGTH, 64'd3);
        write_reg(CFG_ADD_LOW, 64'h0000_002F_7A79_782F);
        write_reg(CFG_ADD_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_ADD_LENGTH, 64'd5);
        // A full match, a line cut short by its newline, a mismatch part way into the
        // prefix, and a payload that ends with prefix bytes still held.
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h71, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h61, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(NEWLINE_BYTE, 1'b0);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h61, 1'b1);
        drain_pipeline();

        // Registers rewritten while bytes are held: first the strip length drops to zero,
        // which flushes the held bytes ahead of the next one.
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h61, 1'b0);
        drain_pipeline();
        write_reg(CFG_STRIP_LENGTH, 64'd0);
        queue_byte(8'h7A, 1'b0);
        drain_pipeline();
        // Then the prefix bytes change and the length falls to the held count, so the
        // next byte is a mismatch and the held bytes come back in their new values.
        write_reg(CFG_STRIP_LENGTH, 64'd3);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h61, 1'b0);
        drain_pipeline();
        write_reg(CFG_STRIP_LOW, 64'h0000_0000_002F_6E2F);
        write_reg(CFG_STRIP_LENGTH, 64'd2);
        queue_byte(8'h6B, 1'b1);
        drain_pipeline();

        // Random part, through several register settings. The longest prefix is removed
        // and nothing put back.
        program_prefixes(5'd16, 5'd0);
        queue_phase(48);
        drain_pipeline();

        // Both lengths beyond the store, which count as sixteen. The spare index must not
        // disturb any register.
        program_prefixes(5'd31, 5'd31);
        write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
        queue_phase(48);
        drain_pipeline();

        // One strip byte grows into sixteen added bytes, so each rewrite is a long burst.
        program_prefixes(5'd1, 5'd16);
        queue_phase(40);
        drain_pipeline();

        // Rewriting switched off while the add registers hold something.
        program_prefixes(5'd0, 5'd7);
        queue_phase(20);
        drain_pipeline();

        // A mid-sized prefix with the long receiver hold; the sender keeps offering.
        program_prefixes(5'd4, 5'd2);
        queue_phase(48);
        pressure_armed = 1'b1;
        drain_pipeline();

        // The tail runs at full rate on both sides.
        quiet = 1'b1;
        program_prefixes(5'd2, 5'd3);
        queue_phase(48);
        drain_pipeline();

        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* line_prefix_rewriter.f */
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_cfg.sv
rtl/lpr_scan.sv
rtl/lpr_emit.sv
rtl/line_prefix_rewriter.sv
tb/sv/tb_line_prefix_rewriter.sv
